// ----- sv/icmpr_pkg.sv -----
// ----------------------------------------------------------------------------
// ICMP echo reply builder package
// Frame offsets, protocol constants, verdict codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpr_pkg;

   // Byte offsets within the Ethernet frame.
   localparam int ETH_HDR       = 14;
   localparam int OFS_TYPE_HI   = 12;
   localparam int OFS_TYPE_LO   = 13;
   localparam int OFS_VER_IHL   = 14;
   localparam int OFS_TLEN_HI   = 16;
   localparam int OFS_TLEN_LO   = 17;
   localparam int OFS_PROTO     = 23;
   localparam int OFS_IP_CSUM   = 24;
   localparam int OFS_IP_SRC    = 26;
   localparam int OFS_IP_DST    = 30;
   localparam int IP_BASE_END   = 34;
   localparam int MAC_BYTES     = 6;

   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [3:0]  IP_VERSION        = 4'd4;
   localparam logic [3:0]  IP_MIN_WORDS      = 4'd5;
   localparam logic [7:0]  PROTO_ICMP        = 8'd1;
   localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
   localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;

   // Verdict codes.
   localparam logic [2:0] V_READY   = 3'd0;
   localparam logic [2:0] V_SHORT   = 3'd1;
   localparam logic [2:0] V_NOT_IP  = 3'd2;
   localparam logic [2:0] V_BAD_HDR = 3'd3;
   localparam logic [2:0] V_NO_ECHO = 3'd4;
   localparam logic [2:0] V_TRUNC   = 3'd5;

   localparam logic RK_VERDICT = 1'b0;
   localparam logic RK_BYTE    = 1'b1;

   // Parsed state of the loaded frame, as seen by the playback side.
   typedef struct packed {
      logic [2:0]  verdict;
      logic [3:0]  header_words;
      logic [15:0] ip_sum;
      logic [15:0] icmp_sum;
   } frame_info_type;

   // Ones-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

`default_nettype wire

// ----- sv/icmpr_store.sv -----
// ----------------------------------------------------------------------------
// Frame store
// Single-port-write, registered-read byte memory holding the received frame.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpr_store #(
   parameter int DEPTH = 2048
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [7:0]               wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]              rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/icmpr_parse.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Counts pushed bytes, captures header fields, accumulates both checksums
// and forms the verdict on the final byte of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpr_parse #(
   parameter int FRAME_BYTES = 2048
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                push,
   input  wire [7:0]                          in_byte,
   input  wire                                in_last,
   output logic                               wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0]     wr_addr,
   output logic [$clog2(FRAME_BYTES+1)-1:0]   count,
   output logic [$clog2(FRAME_BYTES+1)-1:0]   count_next,
   output icmpr_pkg::frame_info_type          info
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int XW = (CW > 17) ? CW + 1 : 18;

   logic [CW-1:0] count_ff, count_in;
   logic          closed_ff, closed_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   ip_sum_ff, ip_sum_in;
   logic [15:0]   icmp_sum_ff, icmp_sum_in;
   logic [7:0]    type_hi_ff, type_lo_ff, ver_ihl_ff, tlen_hi_ff, tlen_lo_ff;
   logic [7:0]    proto_ff, icmp_type_ff;

   logic [CW-1:0] cnt_eff;
   logic          ovf_eff;
   logic [15:0]   ip_sum_eff, icmp_sum_eff;
   logic          full, take;
   logic [15:0]   word;
   logic [3:0]    hw_eff;
   logic [XW-1:0] pos, n_x, tlen_x, icmp_at_x, ip_end_x, icmp_end_x, hdr_min_x;
   logic          in_ip, in_icmp;
   logic [15:0]   ether;
   logic [2:0]    verdict;

   always_comb begin
      // The first push after a closed frame starts from a clean slate.
      cnt_eff      = closed_ff ? '0 : count_ff;
      ovf_eff      = closed_ff ? 1'b0 : ovf_ff;
      ip_sum_eff   = closed_ff ? 16'd0 : ip_sum_ff;
      icmp_sum_eff = closed_ff ? 16'd0 : icmp_sum_ff;

      full = (cnt_eff == CW'(FRAME_BYTES));
      take = push & ~full;
      count_in = take ? cnt_eff + CW'(1) : cnt_eff;
      ovf_in   = ovf_eff | (push & full);
      closed_in = push ? in_last : closed_ff;

      word   = cnt_eff[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
      hw_eff = (cnt_eff == CW'(icmpr_pkg::OFS_VER_IHL)) ? in_byte[3:0] : ver_ihl_ff[3:0];

      pos        = XW'(cnt_eff);
      n_x        = XW'(count_in);
      tlen_x     = XW'({tlen_hi_ff, tlen_lo_ff});
      ip_end_x   = XW'(icmpr_pkg::ETH_HDR) + XW'({hw_eff, 2'b00});
      icmp_at_x  = ip_end_x;
      icmp_end_x = XW'(icmpr_pkg::ETH_HDR) + tlen_x;
      hdr_min_x  = XW'({hw_eff, 2'b00}) + XW'(8);

      // The checksum fields, and the ICMP type that becomes zero, are left out.
      in_ip = (pos >= XW'(icmpr_pkg::ETH_HDR)) && (pos < ip_end_x) &&
              (pos != XW'(icmpr_pkg::OFS_IP_CSUM)) &&
              (pos != XW'(icmpr_pkg::OFS_IP_CSUM + 1));
      in_icmp = (pos >= icmp_at_x) && (pos < icmp_end_x) && (pos != icmp_at_x) &&
                (pos != icmp_at_x + XW'(2)) && (pos != icmp_at_x + XW'(3));

      ip_sum_in   = (take && in_ip) ? icmpr_pkg::ones_add(ip_sum_eff, word) : ip_sum_eff;
      icmp_sum_in = (take && in_icmp) ? icmpr_pkg::ones_add(icmp_sum_eff, word)
                                      : icmp_sum_eff;

      ether = {type_hi_ff,
               (cnt_eff == CW'(icmpr_pkg::OFS_TYPE_LO)) ? in_byte : type_lo_ff};

      if (ovf_in) begin
         verdict = icmpr_pkg::V_TRUNC;
      end else if (n_x < XW'(icmpr_pkg::ETH_HDR)) begin
         verdict = icmpr_pkg::V_SHORT;
      end else if (ether != icmpr_pkg::ETHERTYPE_IPV4) begin
         verdict = icmpr_pkg::V_NOT_IP;
      end else if (n_x < XW'(icmpr_pkg::IP_BASE_END)) begin
         verdict = icmpr_pkg::V_TRUNC;
      end else if ((ver_ihl_ff[7:4] != icmpr_pkg::IP_VERSION) ||
                   (ver_ihl_ff[3:0] < icmpr_pkg::IP_MIN_WORDS) ||
                   (proto_ff != icmpr_pkg::PROTO_ICMP)) begin
         verdict = icmpr_pkg::V_BAD_HDR;
      end else if (tlen_x < hdr_min_x) begin
         verdict = icmpr_pkg::V_BAD_HDR;
      end else if (n_x < icmp_end_x) begin
         verdict = icmpr_pkg::V_TRUNC;
      end else if (icmp_type_ff != icmpr_pkg::ICMP_ECHO_REQUEST) begin
         verdict = icmpr_pkg::V_NO_ECHO;
      end else begin
         verdict = icmpr_pkg::V_READY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         closed_ff   <= 1'b0;
         ovf_ff      <= 1'b0;
         ip_sum_ff   <= 16'd0;
         icmp_sum_ff <= 16'd0;
      end else if (push) begin
         count_ff    <= count_in;
         closed_ff   <= closed_in;
         ovf_ff      <= ovf_in;
         ip_sum_ff   <= ip_sum_in;
         icmp_sum_ff <= icmp_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (cnt_eff == CW'(icmpr_pkg::OFS_TYPE_HI)) type_hi_ff <= in_byte;
         if (cnt_eff == CW'(icmpr_pkg::OFS_TYPE_LO)) type_lo_ff <= in_byte;
         if (cnt_eff == CW'(icmpr_pkg::OFS_VER_IHL)) ver_ihl_ff <= in_byte;
         if (cnt_eff == CW'(icmpr_pkg::OFS_TLEN_HI)) tlen_hi_ff <= in_byte;
         if (cnt_eff == CW'(icmpr_pkg::OFS_TLEN_LO)) tlen_lo_ff <= in_byte;
         if (cnt_eff == CW'(icmpr_pkg::OFS_PROTO))   proto_ff   <= in_byte;
         if (pos == icmp_at_x)                       icmp_type_ff <= in_byte;
      end
   end

   assign wr_en      = take;
   assign wr_addr    = cnt_eff[AW-1:0];
   assign count      = count_ff;
   assign count_next = count_in;

   assign info.verdict      = verdict;
   assign info.header_words = ver_ihl_ff[3:0];
   assign info.ip_sum       = ip_sum_ff;
   assign info.icmp_sum     = icmp_sum_ff;

endmodule

`default_nettype wire

// ----- sv/icmp_echo_reply_builder.sv -----
// ----------------------------------------------------------------------------
// ICMP echo reply builder
// Loads an Ethernet frame, checks it for an IPv4 echo request and plays back
// the echo reply with swapped addresses and recomputed checksums.
// ----------------------------------------------------------------------------
// A verdict or reply byte appears in the cycle after its request.
// Throughput: one request per cycle; busy is never raised, the store has one
// write port for pushes and one registered read port for pulls.
// Reset clears the byte count, parse state and any pending reply; the frame
// store holds no reset value. The receiver cannot stall results.
`default_nettype none

module icmp_echo_reply_builder #(
   parameter int FRAME_BYTES = 2048
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_mode,
   input  wire  [7:0]  req_in_byte,
   input  wire         req_in_last,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [2:0]  rsp_verdict,
   output logic [11:0] rsp_frame_length
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);

   logic accept, push, pull;
   logic st_wr_en;
   logic [AW-1:0] st_wr_addr;
   logic [CW-1:0] count, count_next;
   icmpr_pkg::frame_info_type info;
   logic [7:0] mem_q;

   logic [CW-1:0] ri_ff, ri_in;
   logic          pending_ff, pending_in;
   logic          valid_ff, kind_ff, last_ff, sub_ff;
   logic [7:0]    sub_byte_ff;
   logic [2:0]    verdict_ff;
   logic [11:0]   len_ff;

   logic [CW-1:0] rd_idx, icmp_at, ri_plus;
   logic          sub_c;
   logic [7:0]    sub_byte_c;
   logic [15:0]   ip_csum, icmp_csum;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign push   = accept & ~req_mode;
   assign pull   = accept & req_mode & pending_ff;

   icmpr_parse #(.FRAME_BYTES(FRAME_BYTES)) u_parse (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .wr_en      (st_wr_en),
      .wr_addr    (st_wr_addr),
      .count      (count),
      .count_next (count_next),
      .info       (info)
   );

   always_comb begin
      icmp_at   = CW'(icmpr_pkg::ETH_HDR) + CW'({info.header_words, 2'b00});
      ip_csum   = ~info.ip_sum;
      icmp_csum = ~info.icmp_sum;
      ri_plus   = ri_ff + CW'(1);

      // MAC and IP address fields are read from their swapped partners.
      if (ri_ff < CW'(icmpr_pkg::MAC_BYTES)) begin
         rd_idx = ri_ff + CW'(icmpr_pkg::MAC_BYTES);
      end else if (ri_ff < CW'(2 * icmpr_pkg::MAC_BYTES)) begin
         rd_idx = ri_ff - CW'(icmpr_pkg::MAC_BYTES);
      end else if ((ri_ff >= CW'(icmpr_pkg::OFS_IP_SRC)) &&
                   (ri_ff < CW'(icmpr_pkg::OFS_IP_DST))) begin
         rd_idx = ri_ff + CW'(4);
      end else if ((ri_ff >= CW'(icmpr_pkg::OFS_IP_DST)) &&
                   (ri_ff < CW'(icmpr_pkg::IP_BASE_END))) begin
         rd_idx = ri_ff - CW'(4);
      end else begin
         rd_idx = ri_ff;
      end

      sub_c      = 1'b1;
      sub_byte_c = 8'h00;
      if (ri_ff == CW'(icmpr_pkg::OFS_IP_CSUM)) begin
         sub_byte_c = ip_csum[15:8];
      end else if (ri_ff == CW'(icmpr_pkg::OFS_IP_CSUM + 1)) begin
         sub_byte_c = ip_csum[7:0];
      end else if (ri_ff == icmp_at) begin
         sub_byte_c = icmpr_pkg::ICMP_ECHO_REPLY;
      end else if (ri_ff == icmp_at + CW'(2)) begin
         sub_byte_c = icmp_csum[15:8];
      end else if (ri_ff == icmp_at + CW'(3)) begin
         sub_byte_c = icmp_csum[7:0];
      end else begin
         sub_c = 1'b0;
      end

      ri_in      = ri_ff;
      pending_in = pending_ff;
      if (push) begin
         pending_in = req_in_last && (info.verdict == icmpr_pkg::V_READY);
         ri_in      = '0;
      end else if (pull) begin
         ri_in      = ri_plus;
         pending_in = (ri_plus < count);
      end
   end

   icmpr_store #(.DEPTH(FRAME_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_in_byte),
      .rd_en   (pull),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (mem_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff      <= '0;
         pending_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         ri_ff      <= ri_in;
         pending_ff <= pending_in;
         valid_ff   <= (push & req_in_last) | pull;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff     <= icmpr_pkg::RK_VERDICT;
         last_ff     <= 1'b0;
         sub_ff      <= 1'b0;
         sub_byte_ff <= 8'h00;
         verdict_ff  <= info.verdict;
         len_ff      <= 12'(count_next);
      end else if (pull) begin
         kind_ff     <= icmpr_pkg::RK_BYTE;
         last_ff     <= (ri_plus == count);
         sub_ff      <= sub_c;
         sub_byte_ff <= sub_byte_c;
         verdict_ff  <= icmpr_pkg::V_READY;
         len_ff      <= 12'(count);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_out_byte     = (kind_ff == icmpr_pkg::RK_BYTE) ? (sub_ff ? sub_byte_ff : mem_q)
                                                             : 8'h00;
   assign rsp_out_last     = last_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_frame_length = len_ff;

   // A pending reply always has bytes left to play back.
   a_pending_in_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (ri_ff < count))
      else $error("pending reply with read index past frame end");

   // A pull while a reply is pending yields a reply byte next cycle.
   a_pull_gives_byte: assert property (@(posedge clock) disable iff (reset)
      (start && req_mode && pending_ff) |=> (rsp_valid && rsp_result_kind))
      else $error("pull did not produce a reply byte");

   // A push that is not the final byte produces no result.
   a_mid_push_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !req_mode && !req_in_last) |=> !rsp_valid)
      else $error("result after a non-final push");

   // A verdict arms playback exactly when it reports a ready reply.
   a_verdict_arms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |->
         (pending_ff == (rsp_verdict == icmpr_pkg::V_READY)))
      else $error("pending reply disagrees with verdict");

endmodule

`default_nettype wire
